// ===== design/prvs_pkg.sv =====
// prvs_pkg: shared widths, register indexes, reset values and the control
// struct of the power reading validate and smooth block; no dependencies
`default_nettype none

package prvs_pkg;

   localparam int FRACTION_BITS = 8;

   localparam int WORD_W      = 16;
   localparam int BUS_SHIFT   = 3;
   localparam int BUS_COUNT_W = WORD_W - BUS_SHIFT;
   localparam int CMAG_W      = WORD_W + 1;
   localparam int SHIFT_W     = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int BUS_FILT_W = BUS_COUNT_W + FRACTION_BITS;
   localparam int CUR_FILT_W = WORD_W + FRACTION_BITS;
   localparam int PWR_FILT_W = WORD_W + FRACTION_BITS;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BUS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CURRENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_POWER   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT       = 2'd3;

   // register reset values
   localparam logic [BUS_COUNT_W-1:0] MAX_BUS_RESET     = 13'd6500;
   localparam logic [WORD_W-1:0]      MAX_CURRENT_RESET = 16'd32000;
   localparam logic [WORD_W-1:0]      MAX_POWER_RESET   = 16'd41600;
   localparam logic [SHIFT_W-1:0]     SHIFT_RESET       = 3'd2;

   typedef struct packed {
      logic advance;   // an item moves into the result register this cycle
      logic reject;    // that item failed a range check
   } prvs_ctl_type;

endpackage

`default_nettype wire

// ===== design/prvs_check.sv =====
// prvs_check: range checks of one reading against the limit registers
// depends on prvs_pkg
`default_nettype none

module prvs_check (
   input  wire logic [prvs_pkg::WORD_W-1:0]      bus_word,
   input  wire logic signed [prvs_pkg::WORD_W-1:0] current_word,
   input  wire logic [prvs_pkg::WORD_W-1:0]      power_word,
   input  wire logic [prvs_pkg::BUS_COUNT_W-1:0] max_bus_counts,
   input  wire logic [prvs_pkg::WORD_W-1:0]      max_current_counts,
   input  wire logic [prvs_pkg::WORD_W-1:0]      max_power_counts,
   output logic                                  reject
);
   import prvs_pkg::*;

   logic [BUS_COUNT_W-1:0] bus_counts;
   logic [CMAG_W-1:0]      cur_ext;
   logic [CMAG_W-1:0]      cur_mag;

   assign bus_counts = bus_word[WORD_W-1:BUS_SHIFT];
   assign cur_ext    = {current_word[WORD_W-1], current_word};
   // magnitude of the most negative word needs the extra bit
   assign cur_mag    = current_word[WORD_W-1] ? (~cur_ext + 1'b1) : cur_ext;

   assign reject = (bus_counts > max_bus_counts)
                || (cur_mag > {1'b0, max_current_counts})
                || (power_word > max_power_counts);

endmodule

`default_nettype wire

// ===== design/prvs_filter.sv =====
// prvs_filter: filter state of the three channels and the shift-add update
// depends on prvs_pkg
`default_nettype none

module prvs_filter (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire prvs_pkg::prvs_ctl_type                ctl,
   input  wire logic [prvs_pkg::WORD_W-1:0]           bus_word,
   input  wire logic signed [prvs_pkg::WORD_W-1:0]    current_word,
   input  wire logic [prvs_pkg::WORD_W-1:0]           power_word,
   input  wire logic [prvs_pkg::SHIFT_W-1:0]          smoothing_shift,
   output logic [prvs_pkg::BUS_FILT_W-1:0]            bus_next,
   output logic signed [prvs_pkg::CUR_FILT_W-1:0]     cur_next,
   output logic [prvs_pkg::PWR_FILT_W-1:0]            pwr_next
);
   import prvs_pkg::*;

   logic                  loaded_ff, loaded_in;
   logic [BUS_FILT_W-1:0] bus_ff;
   logic [CUR_FILT_W-1:0] cur_ff;
   logic [PWR_FILT_W-1:0] pwr_ff;

   logic [BUS_FILT_W-1:0] bus_meas;
   logic [CUR_FILT_W-1:0] cur_meas;
   logic [PWR_FILT_W-1:0] pwr_meas;

   logic signed [BUS_FILT_W:0] bus_diff, bus_step, bus_sum;
   logic signed [CUR_FILT_W:0] cur_diff, cur_step, cur_sum;
   logic signed [PWR_FILT_W:0] pwr_diff, pwr_step, pwr_sum;

   assign bus_meas = {bus_word[WORD_W-1:BUS_SHIFT], {FRACTION_BITS{1'b0}}};
   assign cur_meas = {current_word, {FRACTION_BITS{1'b0}}};
   assign pwr_meas = {power_word, {FRACTION_BITS{1'b0}}};

   // filter += (meas - filter) >>> shift, one guard bit each
   assign bus_diff = $signed({1'b0, bus_meas}) - $signed({1'b0, bus_ff});
   assign bus_step = bus_diff >>> smoothing_shift;
   assign bus_sum  = $signed({1'b0, bus_ff}) + bus_step;

   assign cur_diff = $signed({cur_meas[CUR_FILT_W-1], cur_meas})
                   - $signed({cur_ff[CUR_FILT_W-1], cur_ff});
   assign cur_step = cur_diff >>> smoothing_shift;
   assign cur_sum  = $signed({cur_ff[CUR_FILT_W-1], cur_ff}) + cur_step;

   assign pwr_diff = $signed({1'b0, pwr_meas}) - $signed({1'b0, pwr_ff});
   assign pwr_step = pwr_diff >>> smoothing_shift;
   assign pwr_sum  = $signed({1'b0, pwr_ff}) + pwr_step;

   always_comb begin
      loaded_in = loaded_ff;
      bus_next  = bus_ff;
      cur_next  = cur_ff;
      pwr_next  = pwr_ff;
      if (ctl.reject) begin
         loaded_in = 1'b0;
         bus_next  = '0;
         cur_next  = '0;
         pwr_next  = '0;
      end else if (!loaded_ff) begin
         loaded_in = 1'b1;
         bus_next  = bus_meas;
         cur_next  = cur_meas;
         pwr_next  = pwr_meas;
      end else begin
         bus_next  = bus_sum[BUS_FILT_W-1:0];
         cur_next  = cur_sum[CUR_FILT_W-1:0];
         pwr_next  = pwr_sum[PWR_FILT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= 1'b0;
         bus_ff    <= '0;
         cur_ff    <= '0;
         pwr_ff    <= '0;
      end else if (ctl.advance) begin
         loaded_ff <= loaded_in;
         bus_ff    <= bus_next;
         cur_ff    <= cur_next;
         pwr_ff    <= pwr_next;
      end
   end

endmodule

`default_nettype wire

// ===== design/power_reading_validate_smooth.sv =====
// power_reading_validate_smooth: top level, limit registers, input and
// result registers; depends on prvs_pkg, prvs_check and prvs_filter
`default_nettype none

//  channel   ports                                   direction
//  req       req_valid/req_stall, three raw words    in
//  rsp       rsp_valid/rsp_stall, status, filters    out
//  csr       csr_write, csr_index, csr_wdata         in
//
//  one item per clock unless rsp stalls; the edge that takes an item loads
//  the input register, the edge advancing it loads the rsp result register
//  the range check and the shift-add of all three filters sit between them
//  reset clears the valid flags, the filters and loads the limit defaults
//  a stalled result holds; the input register still takes an item, and
//  req_stall rises only once both registers are full

module power_reading_validate_smooth (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // configuration
   input  wire logic                                     csr_write,
   input  wire logic [prvs_pkg::CSR_IDX_W-1:0]           csr_index,
   input  wire logic [prvs_pkg::CSR_DATA_W-1:0]          csr_wdata,
   // readings
   input  wire logic                                     req_valid,
   output logic                                          req_stall,
   input  wire logic [15:0]                              req_bus_word,
   input  wire logic signed [15:0]                       req_current_word,
   input  wire logic [15:0]                              req_power_word,
   // results
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_stall,
   output logic                                          rsp_status,
   output logic [20:0]                                   rsp_smoothed_bus,
   output logic signed [23:0]                            rsp_smoothed_current,
   output logic [23:0]                                   rsp_smoothed_power
);
   import prvs_pkg::*;

   // limit registers
   logic [BUS_COUNT_W-1:0] max_bus_ff;
   logic [WORD_W-1:0]      max_cur_ff;
   logic [WORD_W-1:0]      max_pwr_ff;
   logic [SHIFT_W-1:0]     shift_ff;

   // input register
   logic                     in_valid_ff, in_valid_in;
   logic [WORD_W-1:0]        in_bus_ff;
   logic signed [WORD_W-1:0] in_cur_ff;
   logic [WORD_W-1:0]        in_pwr_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_status_ff;
   logic [BUS_FILT_W-1:0] out_bus_ff;
   logic [CUR_FILT_W-1:0] out_cur_ff;
   logic [PWR_FILT_W-1:0] out_pwr_ff;

   logic                  req_take;
   logic                  reject;
   prvs_ctl_type          ctl;
   logic [BUS_FILT_W-1:0]        bus_next;
   logic signed [CUR_FILT_W-1:0] cur_next;
   logic [PWR_FILT_W-1:0]        pwr_next;

   // register writes, data cut to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bus_ff <= MAX_BUS_RESET;
         max_cur_ff <= MAX_CURRENT_RESET;
         max_pwr_ff <= MAX_POWER_RESET;
         shift_ff   <= SHIFT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_BUS:     max_bus_ff <= csr_wdata[BUS_COUNT_W-1:0];
            CSR_MAX_CURRENT: max_cur_ff <= csr_wdata[WORD_W-1:0];
            CSR_MAX_POWER:   max_pwr_ff <= csr_wdata[WORD_W-1:0];
            CSR_SHIFT:       shift_ff   <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // the held item moves on when the result register is empty or draining
   assign ctl.advance = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign ctl.reject  = reject;
   assign req_stall   = in_valid_ff && !ctl.advance;
   assign req_take    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (ctl.advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (ctl.advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_bus_ff <= req_bus_word;
         in_cur_ff <= req_current_word;
         in_pwr_ff <= req_power_word;
      end
      if (ctl.advance) begin
         out_status_ff <= reject;
         out_bus_ff    <= bus_next;
         out_cur_ff    <= cur_next;
         out_pwr_ff    <= pwr_next;
      end
   end

   prvs_check u_check (
      .bus_word           (in_bus_ff),
      .current_word       (in_cur_ff),
      .power_word         (in_pwr_ff),
      .max_bus_counts     (max_bus_ff),
      .max_current_counts (max_cur_ff),
      .max_power_counts   (max_pwr_ff),
      .reject             (reject)
   );

   prvs_filter u_filter (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .bus_word        (in_bus_ff),
      .current_word    (in_cur_ff),
      .power_word      (in_pwr_ff),
      .smoothing_shift (shift_ff),
      .bus_next        (bus_next),
      .cur_next        (cur_next),
      .pwr_next        (pwr_next)
   );

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_smoothed_bus     = out_bus_ff[20:0];
   assign rsp_smoothed_current = out_cur_ff[23:0];
   assign rsp_smoothed_power   = out_pwr_ff[23:0];

endmodule

`default_nettype wire
